// ===== rtl/jsu_pkg.sv =====
package jsu_pkg;

	localparam logic [7:0] CHR_BSLASH = 8'h5C;
	localparam logic [7:0] CHR_QUOTE  = 8'h22;
	localparam logic [7:0] CHR_U      = 8'h75;
	localparam logic [7:0] CHR_N      = 8'h6E;
	localparam logic [7:0] CHR_R      = 8'h72;
	localparam logic [7:0] CHR_B      = 8'h62;
	localparam logic [7:0] CHR_T      = 8'h74;
	localparam logic [7:0] CHR_F      = 8'h66;
	localparam logic [7:0] SUBST_BYTE = 8'h3F;

	localparam logic [15:0] UTF8_LIM1 = 16'h0080;
	localparam logic [15:0] UTF8_LIM2 = 16'h0800;

	localparam logic [1:0] RUN_LEN1 = 2'd1;
	localparam logic [1:0] RUN_LEN2 = 2'd2;
	localparam logic [1:0] RUN_LEN3 = 2'd3;

	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      count;
		logic            done;
	} run_t;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'b001,
		MODE_ESCAPE = 3'b010,
		MODE_HEX    = 3'b100
	} mode_t;

endpackage

// ===== rtl/jsu_front.sv =====
module jsu_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	input  logic          push,
	input  logic          q_full,
	output logic          q_push,
	output jsu_pkg::run_t q_data
);
	import jsu_pkg::*;

	mode_t       mode_q;
	logic [1:0]  cnt_q;
	logic [15:0] acc_q;

	mode_t       mode_d;
	logic [1:0]  cnt_d;
	logic [15:0] acc_d;
	logic [15:0] acc_next;
	logic        accept;
	run_t        run;

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
		return v;
	endfunction

	function automatic logic [7:0] simple_escape(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			CHR_N:      r = 8'h0A;
			CHR_R:      r = 8'h0D;
			CHR_B:      r = 8'h08;
			CHR_T:      r = 8'h09;
			CHR_F:      r = 8'h0C;
			CHR_BSLASH: r = CHR_BSLASH;
			CHR_QUOTE:  r = CHR_QUOTE;
			default:    r = SUBST_BYTE;
		endcase
		return r;
	endfunction

	assign accept   = push && !q_full;
	assign acc_next = {acc_q[11:0], hex_value(in_byte)};

	always_comb begin
		mode_d    = mode_q;
		cnt_d     = cnt_q;
		acc_d     = acc_q;
		run.bytes = '0;
		run.count = '0;
		run.done  = in_last;
		case (mode_q)
			MODE_ESCAPE: begin
				if (in_byte == CHR_U) begin
					mode_d = MODE_HEX;
					cnt_d  = 2'd0;
					acc_d  = 16'd0;
				end else begin
					run.bytes[0] = simple_escape(in_byte);
					run.count    = RUN_LEN1;
					mode_d       = MODE_NORMAL;
				end
			end
			MODE_HEX: begin
				if (cnt_q == 2'd3) begin
					if (acc_next < UTF8_LIM1) begin
						run.bytes[0] = acc_next[7:0];
						run.count    = RUN_LEN1;
					end else if (acc_next < UTF8_LIM2) begin
						run.bytes[0] = {3'b110, acc_next[10:6]};
						run.bytes[1] = {2'b10, acc_next[5:0]};
						run.count    = RUN_LEN2;
					end else begin
						run.bytes[0] = {4'b1110, acc_next[15:12]};
						run.bytes[1] = {2'b10, acc_next[11:6]};
						run.bytes[2] = {2'b10, acc_next[5:0]};
						run.count    = RUN_LEN3;
					end
					mode_d = MODE_NORMAL;
					cnt_d  = 2'd0;
					acc_d  = 16'd0;
				end else begin
					cnt_d = cnt_q + 2'd1;
					acc_d = acc_next;
				end
			end
			default: begin
				if (in_byte == CHR_BSLASH) begin
					mode_d = MODE_ESCAPE;
				end else begin
					run.bytes[0] = in_byte;
					run.count    = RUN_LEN1;
					mode_d       = MODE_NORMAL;
				end
			end
		endcase
		if (in_last) begin
			if (run.count == 2'd0) begin
				run.bytes[0] = SUBST_BYTE;
				run.count    = RUN_LEN1;
			end
			mode_d = MODE_NORMAL;
			cnt_d  = 2'd0;
			acc_d  = 16'd0;
		end
	end

	assign q_push = accept && (run.count != 2'd0);
	assign q_data = run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			cnt_q  <= 2'd0;
			acc_q  <= 16'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			acc_q  <= acc_d;
		end
	end

`ifndef SYNTHESIS
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_last) |=> (mode_q == MODE_NORMAL && cnt_q == 2'd0 && acc_q == 16'd0))
		else $error("state not cleared after string end");
	a_cnt_in_hex: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd0) |-> (mode_q == MODE_HEX))
		else $error("hex digit count outside hex mode");
	a_last_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_last) |-> q_push)
		else $error("string end produced no result");
`endif

endmodule

// ===== rtl/jsu_fifo.sv =====
module jsu_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  jsu_pkg::run_t wr_data,
	input  logic          rd,
	output jsu_pkg::run_t rd_data,
	output logic          full,
	output logic          empty
);
	import jsu_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	run_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full    = cnt_q == FULL_CNT;
	assign empty   = cnt_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("queue count overflow");
	a_no_underread: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> !empty)
		else $error("read from empty queue");
`endif

endmodule

// ===== rtl/jsu_back.sv =====
module jsu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  jsu_pkg::run_t q_data,
	input  logic          q_empty,
	output logic          q_pop,
	output logic [7:0]    out_byte,
	output logic          run_last,
	output logic          string_done,
	output logic          empty,
	input  logic          pop
);
	import jsu_pkg::*;

	run_t       cur_q;
	logic [1:0] idx_q;
	logic       valid_q;
	logic       take;
	logic       fin;

	always_comb begin
		case (idx_q)
			2'd0:    out_byte = cur_q.bytes[0];
			2'd1:    out_byte = cur_q.bytes[1];
			default: out_byte = cur_q.bytes[2];
		endcase
	end

	assign run_last    = idx_q == (cur_q.count - 2'd1);
	assign string_done = run_last && cur_q.done;
	assign empty       = !valid_q;
	assign take        = pop && valid_q;
	assign fin         = !valid_q || (take && run_last);
	assign q_pop       = fin && !q_empty;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (fin) begin
			valid_q <= !q_empty;
			idx_q   <= 2'd0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

`ifndef SYNTHESIS
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !pop) |=> (valid_q && $stable(idx_q)))
		else $error("result changed while stalled");
	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (idx_q < cur_q.count))
		else $error("byte index beyond run");
`endif

endmodule

// ===== rtl/json_string_unescaper.sv =====
// JSON string body unescaper.
// Input queue side: present in_byte/in_last with push; a request is taken
// at a clock edge where push is high and full is low. in_last marks the
// final byte of a string and returns all escape state to normal afterward.
// Result queue side: while empty is low, out_byte, run_last and string_done
// show the oldest result; pop high at an edge takes it.
// An ordinary byte or simple escape yields one result; the fourth hex digit
// of a \u escape yields one to three UTF-8 bytes; other escape bytes yield
// none, but a final byte (in_last) that yields none yields a substitute byte.
// run_last flags the final byte from one input byte, string_done the final
// byte of the string. A result passes through the queue and then the output
// register before it shows on the output ports. Throughput: one input byte
// per cycle while full is low, one result per cycle while pop is high; the
// decoder writes a whole run per taken byte into a DEPTH-entry queue.
// Stall: when pop stays low the output holds, the queue fills and full
// rises until space frees up.
// Reset: escape state returns to normal copying and the queue empties.
module json_string_unescaper #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       push,
	output logic       full,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       string_done,
	output logic       empty,
	input  logic       pop
);
	import jsu_pkg::*;

	run_t fq_wr_data;
	run_t fq_rd_data;
	logic fq_wr;
	logic fq_rd;
	logic fq_empty;

	jsu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_byte(in_byte),
		.in_last(in_last),
		.push   (push),
		.q_full (full),
		.q_push (fq_wr),
		.q_data (fq_wr_data)
	);

	jsu_fifo #(
		.DEPTH(DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fq_wr),
		.wr_data(fq_wr_data),
		.rd     (fq_rd),
		.rd_data(fq_rd_data),
		.full   (full),
		.empty  (fq_empty)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_data     (fq_rd_data),
		.q_empty    (fq_empty),
		.q_pop      (fq_rd),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.string_done(string_done),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import jsu_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       run_end;
		logic       str_end;
	} unesc_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       push = 1'b0;
	logic       pop = 1'b0;
	logic       full;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_done;
	logic       empty;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold = 0;
	int err_count = 0;
	int tx_count = 0;

	unesc_byte_t unescaped_q[$];
	logic [7:0]  pending_bytes[$];

	mode_t       esc_mode = MODE_NORMAL;
	logic [1:0]  digit_cnt = 2'd0;
	logic [15:0] code_acc = 16'h0000;

	json_string_unescaper DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_byte(in_byte),
		.in_last(in_last),
		.push(push),
		.full(full),
		.out_byte(out_byte),
		.run_last(run_last),
		.string_done(string_done),
		.empty(empty),
		.pop(pop)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return 4'(c - "0");
		if (c >= "a" && c <= "f")
			return 4'(c - "a" + 10);
		if (c >= "A" && c <= "F")
			return 4'(c - "A" + 10);
		return 4'h0;
	endfunction

	function automatic logic [7:0] escape_byte(input logic [7:0] c);
		case (c)
			CHR_N:      return 8'h0A;
			CHR_R:      return 8'h0D;
			CHR_B:      return 8'h08;
			CHR_T:      return 8'h09;
			CHR_F:      return 8'h0C;
			CHR_BSLASH: return CHR_BSLASH;
			CHR_QUOTE:  return CHR_QUOTE;
			default:    return SUBST_BYTE;
		endcase
	endfunction

	task automatic unescape_request(input logic [7:0] c, input logic last);
		logic [7:0]  run [3];
		int          n;
		unesc_byte_t r;
		n = 0;
		case (esc_mode)
			MODE_ESCAPE: begin
				if (c == CHR_U) begin
					esc_mode = MODE_HEX;
					digit_cnt = 2'd0;
					code_acc = 16'h0000;
				end else begin
					run[0] = escape_byte(c);
					n = 1;
					esc_mode = MODE_NORMAL;
				end
			end
			MODE_HEX: begin
				code_acc = {code_acc[11:0], hex_nibble(c)};
				if (digit_cnt == 2'd3) begin
					if (code_acc < UTF8_LIM1) begin
						run[0] = code_acc[7:0];
						n = 1;
					end else if (code_acc < UTF8_LIM2) begin
						run[0] = 8'hC0 | {3'b000, code_acc[10:6]};
						run[1] = 8'h80 | {2'b00, code_acc[5:0]};
						n = 2;
					end else begin
						run[0] = 8'hE0 | {4'h0, code_acc[15:12]};
						run[1] = 8'h80 | {2'b00, code_acc[11:6]};
						run[2] = 8'h80 | {2'b00, code_acc[5:0]};
						n = 3;
					end
					esc_mode = MODE_NORMAL;
					digit_cnt = 2'd0;
					code_acc = 16'h0000;
				end else begin
					digit_cnt = digit_cnt + 2'd1;
				end
			end
			default: begin
				if (c == CHR_BSLASH) begin
					esc_mode = MODE_ESCAPE;
				end else begin
					run[0] = c;
					n = 1;
					esc_mode = MODE_NORMAL;
				end
			end
		endcase
		if (last) begin
			if (n == 0) begin
				run[0] = SUBST_BYTE;
				n = 1;
			end
			esc_mode = MODE_NORMAL;
			digit_cnt = 2'd0;
			code_acc = 16'h0000;
		end
		for (int k = 0; k < n; k++) begin
			r.data = run[k];
			r.run_end = (k == n - 1);
			r.str_end = (k == n - 1) && last;
			unescaped_q.push_back(r);
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("tb: mismatch at %0t: %s", $time, msg);
		err_count++;
	endtask

	task automatic send_byte(input logic [7:0] c, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		in_byte <= c;
		in_last <= last;
		do @(posedge clk); while (full);
		unescape_request(c, last);
		tx_count++;
	endtask

	task automatic send_pending();
		foreach (pending_bytes[i])
			send_byte(pending_bytes[i], i == pending_bytes.size() - 1);
		pending_bytes.delete();
	endtask

	task automatic drain_results();
		@(negedge clk);
		push <= 1'b0;
		while (unescaped_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic add_hex_escape(input int digits);
		logic [15:0] code;
		logic [3:0]  v;
		case ($urandom_range(2))
			0:       code = 16'($urandom_range(16'h007F));
			1:       code = 16'($urandom_range(16'h07FF, 16'h0080));
			default: code = 16'($urandom_range(16'hFFFF, 16'h0800));
		endcase
		pending_bytes.push_back(CHR_BSLASH);
		pending_bytes.push_back(CHR_U);
		for (int d = 0; d < digits; d++) begin
			v = code[15 - 4 * d -: 4];
			if ($urandom_range(11) == 0)
				pending_bytes.push_back(8'($urandom_range(255)));
			else if (v < 10)
				pending_bytes.push_back(8'("0" + v));
			else if ($urandom_range(1))
				pending_bytes.push_back(8'("A" + v - 10));
			else
				pending_bytes.push_back(8'("a" + v - 10));
		end
	endtask

	task automatic send_random_strings(input int count);
		logic [7:0] simple_set [7];
		logic [7:0] c;
		int         stop_at;
		simple_set = '{CHR_N, CHR_R, CHR_B, CHR_T, CHR_F, CHR_BSLASH, CHR_QUOTE};
		stop_at = tx_count + count;
		while (tx_count < stop_at) begin
			repeat ($urandom_range(6, 1)) begin
				case ($urandom_range(9))
					0, 1, 2, 3: begin
						do c = 8'($urandom_range(255)); while (c == CHR_BSLASH);
						pending_bytes.push_back(c);
					end
					4: pending_bytes.push_back(8'($urandom_range(255)));
					5, 6: begin
						pending_bytes.push_back(CHR_BSLASH);
						pending_bytes.push_back(simple_set[$urandom_range(6)]);
					end
					7: begin
						pending_bytes.push_back(CHR_BSLASH);
						pending_bytes.push_back(8'($urandom_range(255)));
					end
					default: add_hex_escape(4);
				endcase
			end
			case ($urandom_range(9))
				0: pending_bytes.push_back(CHR_BSLASH);
				1: add_hex_escape($urandom_range(3));
				default: ;
			endcase
			send_pending();
		end
	endtask

	task automatic test_directed();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		pending_bytes = '{8'h00, 8'hFF};
		send_pending();
		pending_bytes = '{CHR_BSLASH, CHR_N, CHR_BSLASH, CHR_T, CHR_BSLASH, CHR_BSLASH,
			CHR_BSLASH, CHR_QUOTE, CHR_BSLASH, "q", CHR_BSLASH, CHR_F};
		send_pending();
		pending_bytes = '{CHR_BSLASH, CHR_U, "F", "f", 8'hC8, "a",
			CHR_BSLASH, CHR_U, "0", "0", "4", "G"};
		send_pending();
		pending_bytes = '{CHR_BSLASH};
		send_pending();
		pending_bytes = '{CHR_BSLASH, CHR_U, "1"};
		send_pending();
		drain_results();
	endtask

	task automatic test_random_traffic();
		tx_idle_pct = 9;
		rx_idle_pct = 69;
		send_random_strings(22);
		tx_idle_pct = 69;
		rx_idle_pct = 9;
		send_random_strings(22);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_random_strings(22);
		drain_results();
	endtask

	task automatic test_output_stall();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold = 50;
		send_random_strings(12);
		drain_results();
	endtask

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : check_output
		unesc_byte_t want;
		if (arst_n && pop && !empty) begin
			if (unescaped_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result byte %02h", out_byte));
			end else begin
				want = unescaped_q.pop_front();
				if (out_byte !== want.data)
					report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
				if (run_last !== want.run_end)
					report_mismatch($sformatf("run_last %b, want %b", run_last, want.run_end));
				if (string_done !== want.str_end)
					report_mismatch($sformatf("string_done %b, want %b",
						string_done, want.str_end));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_traffic();
		test_output_stall();
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
